FILE: hdl/v3fx_pkg.sv
package v3fx_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int EFF_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;

  // derived widths
  localparam int XW   = EFF_BITS + 1;          // operand with one guard bit
  localparam int PW   = 2 * XW;                // full product
  localparam int NUMW = EFF_BITS + FRAC_BITS;  // divider dividend / quotient
  localparam int RADW = 2 * EFF_BITS;          // square root radicand
  localparam int SRW  = EFF_BITS + 2;          // square root remainder

  typedef logic signed [EFF_BITS-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(EFF_BITS-1){1'b1}}};
  localparam fx_t FX_MIN = ~FX_MAX;
  localparam logic signed [PW-1:0] SAT_HI = PW'(FX_MAX);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_SADD  = 4'd4,
    OP_SSUB  = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SDIV  = 4'd7,
    OP_DOT   = 4'd8,
    OP_CROSS = 4'd9,
    OP_DIST  = 4'd10,
    OP_NORM  = 4'd11,
    OP_EQUAL = 4'd12
  } opcode_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } v3fx_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic               is_equal;
    logic [1:0]         status;
  } v3fx_out_t;

  // item record carried down the pipeline
  typedef struct packed {
    logic [3:0]                     op;
    fx_t [2:0]                      r;
    fx_t                            s;
    logic                           eq;
    logic                           ovf;
    logic                           dz;
    logic                           big;
    logic [2:0]                     neg;
    logic [2:0][EFF_BITS-1:0]       den;
    logic [2:0][NUMW-1:0]           num;
  } v3fx_rec_t;

  typedef struct packed {
    logic ovf;
    fx_t  v;
  } sat_t;

  // clamp a wide signed value into the fixed-point range
  function automatic sat_t sat_fn(input logic signed [PW-1:0] v);
    sat_t res;
    res.ovf = 1'b0;
    res.v   = v[EFF_BITS-1:0];
    if (v > SAT_HI) begin
      res.ovf = 1'b1;
      res.v   = FX_MAX;
    end else if (v < SAT_LO) begin
      res.ovf = 1'b1;
      res.v   = FX_MIN;
    end
    return res;
  endfunction

  // take the used low bits of a field and sign-extend to operand width
  function automatic logic signed [XW-1:0] fld(input logic [31:0] x);
    fx_t t;
    t = x[EFF_BITS-1:0];
    return XW'(t);
  endfunction

endpackage

FILE: hdl/vec3_fixed_point_alu.sv
// Three-component Q16.16 vector ALU.
// Input: drive in_data with start high; a beat is taken on a clock edge where
// start is high and busy is low. busy is high only during reset and the cycle
// after it, so one beat can be taken every cycle.
// Output: every accepted beat gives exactly one result beat on out_data,
// marked by out_valid for a single cycle, in acceptance order. The receiver
// cannot stall; it must take each beat as it appears.
// Pipeline: input, operand and multiply registers, product scaling, 32 square
// root stages, one magnitude stage, 48 divider stages, one output stage.
// Throughput is one item per cycle for every opcode.
// The fixed latency comes from the bit-per-stage square root and the
// bit-per-stage divider that every item passes through.
// Reset: synchronous, active low; clears all valid bits so no result beat is
// produced from items in flight at reset. No other state is kept.
module vec3_fixed_point_alu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  v3fx_pkg::v3fx_in_t    in_data,
  output logic                  out_valid,
  output v3fx_pkg::v3fx_out_t   out_data
);
  import v3fx_pkg::*;

  localparam logic [NUMW-1:0] Q_MAX = NUMW'(FX_MAX);
  localparam logic [NUMW-1:0] Q_NEG = NUMW'(FX_MAX) + NUMW'(1);

  // ---------------------------------------------------------------
  // valid chain
  logic                busy_r;
  logic                v0_r, v1_r, v2_r;
  logic [EFF_BITS:0]   sv_r;
  logic [NUMW:0]       dv_r;
  logic                out_valid_r;
  logic                accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sv_r        <= '0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v0_r        <= accept;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      sv_r        <= {sv_r[EFF_BITS-1:0], v2_r};
      dv_r        <= {dv_r[NUMW-1:0], sv_r[EFF_BITS]};
      out_valid_r <= dv_r[NUMW];
    end
  end

  // ---------------------------------------------------------------
  // stage 0: input register
  v3fx_in_t in_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: operand select, add/sub, compare, divider setup
  logic signed [XW-1:0] a_s [3];
  logic signed [XW-1:0] b_s [3];
  logic signed [XW-1:0] ma_nxt [6];
  logic signed [XW-1:0] mb_nxt [6];
  v3fx_rec_t            rec1_nxt;

  always_comb begin
    logic signed [XW-1:0] o;
    logic signed [XW-1:0] d;
    logic [XW-1:0]        mag;
    logic [XW-1:0]        omag;
    logic                 is_s;
    sat_t                 st;
    a_s[0] = fld(in_r.a_x);
    a_s[1] = fld(in_r.a_y);
    a_s[2] = fld(in_r.a_z);
    b_s[0] = fld(in_r.b_x);
    b_s[1] = fld(in_r.b_y);
    b_s[2] = fld(in_r.b_z);
    is_s = (in_r.opcode >= OP_SADD) && (in_r.opcode <= OP_SDIV);
    rec1_nxt    = '0;
    rec1_nxt.op = in_r.opcode;
    for (int k = 0; k < 6; k++) begin
      ma_nxt[k] = '0;
      mb_nxt[k] = '0;
    end
    o    = '0;
    d    = '0;
    mag  = '0;
    omag = '0;
    st   = '0;
    case (in_r.opcode)
      OP_ADD, OP_SUB, OP_SADD, OP_SSUB: begin
        for (int i = 0; i < 3; i++) begin
          o = is_s ? b_s[0] : b_s[i];
          if (in_r.opcode == OP_ADD || in_r.opcode == OP_SADD) begin
            st = sat_fn(PW'(a_s[i] + o));
          end else begin
            st = sat_fn(PW'(a_s[i] - o));
          end
          rec1_nxt.r[i] = st.v;
          rec1_nxt.ovf  = rec1_nxt.ovf | st.ovf;
        end
      end
      OP_MUL, OP_SMUL: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = a_s[i];
          mb_nxt[i] = is_s ? b_s[0] : b_s[i];
        end
      end
      OP_DIV, OP_SDIV: begin
        for (int i = 0; i < 3; i++) begin
          o    = is_s ? b_s[0] : b_s[i];
          mag  = a_s[i][XW-1] ? XW'(-a_s[i]) : XW'(a_s[i]);
          omag = o[XW-1] ? XW'(-o) : XW'(o);
          rec1_nxt.neg[i] = a_s[i][XW-1] ^ o[XW-1];
          rec1_nxt.num[i] = NUMW'(mag) << FRAC_BITS;
          rec1_nxt.den[i] = omag[EFF_BITS-1:0];
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = a_s[i];
          mb_nxt[i] = b_s[i];
        end
      end
      OP_CROSS: begin
        ma_nxt[0] = a_s[1]; mb_nxt[0] = b_s[2];
        ma_nxt[1] = a_s[2]; mb_nxt[1] = b_s[0];
        ma_nxt[2] = a_s[0]; mb_nxt[2] = b_s[1];
        ma_nxt[3] = a_s[2]; mb_nxt[3] = b_s[1];
        ma_nxt[4] = a_s[0]; mb_nxt[4] = b_s[2];
        ma_nxt[5] = a_s[1]; mb_nxt[5] = b_s[0];
      end
      OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          d   = a_s[i] - b_s[i];
          mag = d[XW-1] ? XW'(-d) : XW'(d);
          if (mag > XW'(FX_MAX)) begin
            rec1_nxt.big = 1'b1;
          end else begin
            ma_nxt[i] = mag;
            mb_nxt[i] = mag;
          end
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mag = a_s[i][XW-1] ? XW'(-a_s[i]) : XW'(a_s[i]);
          ma_nxt[i] = mag;
          mb_nxt[i] = mag;
          rec1_nxt.neg[i] = a_s[i][XW-1];
          rec1_nxt.num[i] = NUMW'(mag) << FRAC_BITS;
        end
      end
      OP_EQUAL: begin
        rec1_nxt.eq = (a_s[0] == b_s[0]) && (a_s[1] == b_s[1]) && (a_s[2] == b_s[2]);
      end
      default: begin
      end
    endcase
  end

  logic signed [XW-1:0] ma_r [6];
  logic signed [XW-1:0] mb_r [6];
  v3fx_rec_t            rec1_r;

  // ---------------------------------------------------------------
  // stage 2: six parallel multipliers
  logic signed [PW-1:0] p_r [6];
  v3fx_rec_t            rec2_r;

  always_ff @(posedge clk) begin
    rec1_r <= rec1_nxt;
    rec2_r <= rec1_r;
    for (int k = 0; k < 6; k++) begin
      ma_r[k] <= ma_nxt[k];
      mb_r[k] <= mb_nxt[k];
      p_r[k]  <= ma_r[k] * mb_r[k];
    end
  end

  // ---------------------------------------------------------------
  // stage 3: scale products, sums, radicand
  v3fx_rec_t         rec3_nxt;
  logic [RADW-1:0]   rad3_nxt;

  always_comb begin
    logic signed [PW-1:0] sh [6];
    logic signed [PW-1:0] acc;
    sat_t                 st;
    for (int k = 0; k < 6; k++) begin
      sh[k] = p_r[k] >>> FRAC_BITS;
    end
    rec3_nxt = rec2_r;
    acc      = '0;
    rad3_nxt = '0;
    st       = '0;
    case (rec2_r.op)
      OP_MUL, OP_SMUL: begin
        for (int i = 0; i < 3; i++) begin
          st = sat_fn(sh[i]);
          rec3_nxt.r[i] = st.v;
          rec3_nxt.ovf  = rec3_nxt.ovf | st.ovf;
        end
      end
      OP_DOT: begin
        st = sat_fn(sh[0] + sh[1] + sh[2]);
        rec3_nxt.s   = st.v;
        rec3_nxt.ovf = st.ovf;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          st = sat_fn(sh[i] - sh[i+3]);
          rec3_nxt.r[i] = st.v;
          rec3_nxt.ovf  = rec3_nxt.ovf | st.ovf;
        end
      end
      OP_DIST, OP_NORM: begin
        acc      = p_r[0] + p_r[1] + p_r[2];
        rad3_nxt = acc[RADW-1:0];
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // square root: one result bit per stage
  v3fx_rec_t             srec_r  [EFF_BITS+1];
  logic [RADW-1:0]       srad_r  [EFF_BITS+1];
  logic [SRW-1:0]        srem_r  [EFF_BITS+1];
  logic [EFF_BITS-1:0]   sroot_r [EFF_BITS+1];
  logic [SRW-1:0]        srem_nxt  [EFF_BITS];
  logic [EFF_BITS-1:0]   sroot_nxt [EFF_BITS];

  always_comb begin
    logic [SRW-1:0] cur;
    logic [SRW-1:0] trial;
    for (int k = 0; k < EFF_BITS; k++) begin
      cur   = {srem_r[k][SRW-3:0], srad_r[k][RADW-1 -: 2]};
      trial = {sroot_r[k], 2'b01};
      if (cur >= trial) begin
        srem_nxt[k]  = cur - trial;
        sroot_nxt[k] = {sroot_r[k][EFF_BITS-2:0], 1'b1};
      end else begin
        srem_nxt[k]  = cur;
        sroot_nxt[k] = {sroot_r[k][EFF_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    srec_r[0]  <= rec3_nxt;
    srad_r[0]  <= rad3_nxt;
    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
    for (int k = 0; k < EFF_BITS; k++) begin
      srec_r[k+1]  <= srec_r[k];
      srad_r[k+1]  <= srad_r[k] << 2;
      srem_r[k+1]  <= srem_nxt[k];
      sroot_r[k+1] <= sroot_nxt[k];
    end
  end

  // ---------------------------------------------------------------
  // magnitude stage: distance result, normalize divisor
  v3fx_rec_t recd_nxt;

  always_comb begin
    logic [EFF_BITS-1:0] root;
    root     = sroot_r[EFF_BITS];
    recd_nxt = srec_r[EFF_BITS];
    case (srec_r[EFF_BITS].op)
      OP_DIST: begin
        if (srec_r[EFF_BITS].big || root[EFF_BITS-1]) begin
          recd_nxt.s   = FX_MAX;
          recd_nxt.ovf = 1'b1;
        end else begin
          recd_nxt.s = root;
        end
      end
      OP_NORM: begin
        if (root == '0) begin
          recd_nxt.dz = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            recd_nxt.den[i] = root;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // divider: restoring, one quotient bit per stage, three lanes
  v3fx_rec_t            drec_r [NUMW+1];
  logic [EFF_BITS-1:0]  drem_r [NUMW+1][3];
  v3fx_rec_t            drec_nxt [NUMW];
  logic [EFF_BITS-1:0]  drem_nxt [NUMW][3];

  always_comb begin
    logic [EFF_BITS:0] t;
    logic [EFF_BITS:0] dd;
    logic [EFF_BITS:0] diff;
    for (int j = 0; j < NUMW; j++) begin
      drec_nxt[j] = drec_r[j];
      for (int i = 0; i < 3; i++) begin
        t  = {drem_r[j][i], drec_r[j].num[i][NUMW-1]};
        dd = {1'b0, drec_r[j].den[i]};
        diff = t - dd;
        if (t >= dd) begin
          drem_nxt[j][i]        = diff[EFF_BITS-1:0];
          drec_nxt[j].num[i]    = {drec_r[j].num[i][NUMW-2:0], 1'b1};
        end else begin
          drem_nxt[j][i]        = t[EFF_BITS-1:0];
          drec_nxt[j].num[i]    = {drec_r[j].num[i][NUMW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    drec_r[0] <= recd_nxt;
    for (int i = 0; i < 3; i++) begin
      drem_r[0][i] <= '0;
    end
    for (int j = 0; j < NUMW; j++) begin
      drec_r[j+1] <= drec_nxt[j];
      for (int i = 0; i < 3; i++) begin
        drem_r[j+1][i] <= drem_nxt[j][i];
      end
    end
  end

  // ---------------------------------------------------------------
  // output stage: quotient sign and clamp, status
  v3fx_out_t out_nxt;
  v3fx_out_t out_r;

  always_comb begin
    v3fx_rec_t       f;
    logic [NUMW-1:0] q;
    f = drec_r[NUMW];
    q = '0;
    if (f.op == OP_DIV || f.op == OP_SDIV || (f.op == OP_NORM && !f.dz)) begin
      for (int i = 0; i < 3; i++) begin
        q = f.num[i];
        if (f.den[i] == '0) begin
          f.dz   = 1'b1;
          f.r[i] = '0;
        end else if (f.neg[i]) begin
          if (q > Q_NEG) begin
            f.r[i] = FX_MIN;
            f.ovf  = 1'b1;
          end else begin
            f.r[i] = -q[EFF_BITS-1:0];
          end
        end else begin
          if (q > Q_MAX) begin
            f.r[i] = FX_MAX;
            f.ovf  = 1'b1;
          end else begin
            f.r[i] = q[EFF_BITS-1:0];
          end
        end
      end
    end
    out_nxt.r_x      = 32'(signed'(f.r[0]));
    out_nxt.r_y      = 32'(signed'(f.r[1]));
    out_nxt.r_z      = 32'(signed'(f.r[2]));
    out_nxt.r_scalar = 32'(signed'(f.s));
    out_nxt.is_equal = f.eq;
    out_nxt.status   = f.dz ? ST_DZ : (f.ovf ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------
`ifndef ASSERT_OFF
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_equal |->
      out_r.r_x == 0 && out_r.r_y == 0 && out_r.r_z == 0 &&
      out_r.r_scalar == 0 && out_r.status == ST_OK)
    else $error("equal flag with nonzero result");

  a_dz_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_DZ |-> out_r.r_scalar == 0 && !out_r.is_equal)
    else $error("divide by zero on a scalar-result op");

  a_scalar_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.r_scalar != 0 |->
      out_r.r_x == 0 && out_r.r_y == 0 && out_r.r_z == 0)
    else $error("scalar and vector result both nonzero");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && busy_r)
    else $error("result beat right after reset");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import v3fx_pkg::*;

  localparam int LATENCY   = 85;
  localparam int N_RANDOM  = 1000;
  localparam int MAX_CYCLE = 200000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  v3fx_in_t  in_data;
  logic      out_valid;
  v3fx_out_t out_data;

  v3fx_out_t alu_expected_q[$];
  int        err_count;
  int        cycle_count;

  vec3_fixed_point_alu u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Q16.16 helpers
  function automatic longint fl_shift(longint v);
    if (v < 0) return ~((~v) >>> FRAC_BITS);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint q_div(longint a, longint b, ref bit ovf, ref bit dz);
    if (b == 0) begin
      dz = 1'b1;
      return 0;
    end
    return clamp32((a * 65536) / b, ovf);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // compute the expected output beat for one input beat
  function automatic v3fx_out_t alu_result(v3fx_in_t it);
    v3fx_out_t o;
    longint a[3], b[3], r[3], s, opd, d;
    longint unsigned sum, ad, mag;
    bit ovf, dz, eq, big;
    a[0] = longint'(it.a_x); a[1] = longint'(it.a_y); a[2] = longint'(it.a_z);
    b[0] = longint'(it.b_x); b[1] = longint'(it.b_y); b[2] = longint'(it.b_z);
    r = '{0, 0, 0};
    s = 0; ovf = 0; dz = 0; eq = 0; big = 0; sum = 0;
    if (it.opcode <= OP_SDIV) begin
      for (int i = 0; i < 3; i++) begin
        opd = (it.opcode >= OP_SADD) ? b[0] : b[i];
        case (it.opcode[1:0])
          2'd0: r[i] = clamp32(a[i] + opd, ovf);
          2'd1: r[i] = clamp32(a[i] - opd, ovf);
          2'd2: r[i] = clamp32(fl_shift(a[i] * opd), ovf);
          default: r[i] = q_div(a[i], opd, ovf, dz);
        endcase
      end
    end else if (it.opcode == OP_DOT) begin
      s = clamp32(fl_shift(a[0] * b[0]) + fl_shift(a[1] * b[1]) + fl_shift(a[2] * b[2]), ovf);
    end else if (it.opcode == OP_CROSS) begin
      r[0] = clamp32(fl_shift(a[1] * b[2]) - fl_shift(a[2] * b[1]), ovf);
      r[1] = clamp32(fl_shift(a[2] * b[0]) - fl_shift(a[0] * b[2]), ovf);
      r[2] = clamp32(fl_shift(a[0] * b[1]) - fl_shift(a[1] * b[0]), ovf);
    end else if (it.opcode == OP_DIST) begin
      for (int i = 0; i < 3; i++) begin
        d = a[i] - b[i];
        ad = (d < 0) ? -d : d;
        if (ad > 64'd2147483647) big = 1'b1;
        else sum += ad * ad;
      end
      if (big) s = clamp32(64'sd2147483648, ovf);
      else s = clamp32(longint'(floor_sqrt(sum)), ovf);
    end else if (it.opcode == OP_NORM) begin
      for (int i = 0; i < 3; i++) begin
        ad = (a[i] < 0) ? -a[i] : a[i];
        sum += ad * ad;
      end
      mag = floor_sqrt(sum);
      if (mag == 0) dz = 1'b1;
      else for (int i = 0; i < 3; i++) r[i] = q_div(a[i], longint'(mag), ovf, dz);
    end else if (it.opcode == OP_EQUAL) begin
      eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
    end
    o.r_x = r[0][31:0];
    o.r_y = r[1][31:0];
    o.r_z = r[2][31:0];
    o.r_scalar = s[31:0];
    o.is_equal = eq;
    o.status = dz ? ST_DZ : (ovf ? ST_SAT : ST_OK);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("MISMATCH %s: got %0h expected %0h", what, got, exp_v);
    err_count++;
  endtask

  // output monitor
  always @(posedge clk) begin
    v3fx_out_t e;
    if (rst_n && out_valid) begin
      if (alu_expected_q.size() == 0) begin
        report_mismatch("unexpected beat", longint'(out_data.r_x), 64'sd0);
      end else begin
        e = alu_expected_q.pop_front();
        if (out_data.r_x !== e.r_x)
          report_mismatch("r_x", longint'(out_data.r_x), longint'(e.r_x));
        if (out_data.r_y !== e.r_y)
          report_mismatch("r_y", longint'(out_data.r_y), longint'(e.r_y));
        if (out_data.r_z !== e.r_z)
          report_mismatch("r_z", longint'(out_data.r_z), longint'(e.r_z));
        if (out_data.r_scalar !== e.r_scalar)
          report_mismatch("r_scalar", longint'(out_data.r_scalar), longint'(e.r_scalar));
        if (out_data.is_equal !== e.is_equal)
          report_mismatch("is_equal", longint'(out_data.is_equal), longint'(e.is_equal));
        if (out_data.status !== e.status)
          report_mismatch("status", longint'(out_data.status), longint'(e.status));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one beat: raise start at a falling edge, hold until taken
  task automatic send_beat(v3fx_in_t it, bit has_typed, v3fx_out_t typed);
    v3fx_out_t pred;
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pred = alu_result(it);
    if (has_typed) begin
      if (typed !== pred)
        report_mismatch("typed row", longint'(64'(typed)), longint'(64'(pred)));
      alu_expected_q.push_back(typed);
    end else begin
      alu_expected_q.push_back(pred);
    end
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      3: return 32'(int'($urandom_range(0, 8)) - 4);
      4: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
    endcase
  endfunction

  typedef struct {
    v3fx_in_t  it;
    bit        has_typed;
    v3fx_out_t typed;
  } stim_row_t;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXW = 32'h7fff_ffff;
  localparam logic [31:0] MINW = 32'h8000_0000;

  function automatic v3fx_out_t outv(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [31:0] s, logic eq, logic [1:0] st);
    v3fx_out_t o;
    o.r_x = x; o.r_y = y; o.r_z = z; o.r_scalar = s; o.is_equal = eq; o.status = st;
    return o;
  endfunction

  function automatic v3fx_in_t inv(logic [3:0] op, logic [31:0] ax, logic [31:0] ay,
                                   logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                   logic [31:0] bz);
    v3fx_in_t it;
    it.opcode = op; it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_x = bx; it.b_y = by; it.b_z = bz;
    return it;
  endfunction

  initial begin
    stim_row_t rows[$];
    v3fx_in_t  it;
    int        kind;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    err_count = 0;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table; typed rows carry their result, the rest use the predictor
    rows.push_back('{inv(OP_ADD, ONE, 2*ONE, 3*ONE, ONE, ONE, ONE), 1,
                     outv(2*ONE, 3*ONE, 4*ONE, 0, 0, ST_OK)});
    rows.push_back('{inv(OP_ADD, MAXW, MINW, 0, ONE, MINW, 0), 1,
                     outv(MAXW, MINW, 0, 0, 0, ST_SAT)});
    rows.push_back('{inv(OP_SUB, MINW, MAXW, 5, ONE, MINW, 5), 1,
                     outv(MINW, MAXW, 0, 0, 0, ST_SAT)});
    rows.push_back('{inv(OP_MUL, MAXW, MINW, 3*ONE, MAXW, MINW, 32'hffff8000), 0, '0});
    rows.push_back('{inv(OP_DIV, ONE, 5, MINW, 0, 0, 32'hffffffff), 1,
                     outv(0, 0, MAXW, 0, 0, ST_DZ)});
    rows.push_back('{inv(OP_DIV, 7*ONE, MINW, 32'hfff9_0000, 2*ONE, 3, 3*ONE), 0, '0});
    rows.push_back('{inv(OP_SADD, ONE, MAXW, MINW, ONE, 0, 0), 0, '0});
    rows.push_back('{inv(OP_SSUB, ONE, MAXW, MINW, 32'hffff0000, 0, 0), 0, '0});
    rows.push_back('{inv(OP_SMUL, MAXW, MINW, 32'hffffffff, 32'h0000_8000, 0, 0), 0, '0});
    rows.push_back('{inv(OP_SDIV, ONE, 2, 3, 0, 9, 9), 1, outv(0, 0, 0, 0, 0, ST_DZ)});
    rows.push_back('{inv(OP_SDIV, MAXW, MINW, 3, 32'h0000_0001, 9, 9), 0, '0});
    rows.push_back('{inv(OP_DOT, ONE, ONE, ONE, ONE, 2*ONE, 3*ONE), 1,
                     outv(0, 0, 0, 6*ONE, 0, ST_OK)});
    rows.push_back('{inv(OP_DOT, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW), 0, '0});
    rows.push_back('{inv(OP_CROSS, ONE, 0, 0, 0, ONE, 0), 1, outv(0, 0, ONE, 0, 0, ST_OK)});
    rows.push_back('{inv(OP_CROSS, MINW, MAXW, MINW, MAXW, MINW, MAXW), 0, '0});
    rows.push_back('{inv(OP_DIST, 3, 4, 0, 0, 0, 0), 1, outv(0, 0, 0, 5, 0, ST_OK)});
    rows.push_back('{inv(OP_DIST, MAXW, 0, 0, MINW, 0, 0), 1,
                     outv(0, 0, 0, MAXW, 0, ST_SAT)});
    rows.push_back('{inv(OP_DIST, MAXW, MAXW, MAXW, 0, 0, 0), 0, '0});
    rows.push_back('{inv(OP_NORM, 0, 0, 0, 1, 2, 3), 1, outv(0, 0, 0, 0, 0, ST_DZ)});
    rows.push_back('{inv(OP_NORM, 1, 0, 0, 0, 0, 0), 1, outv(ONE, 0, 0, 0, 0, ST_OK)});
    rows.push_back('{inv(OP_NORM, 3*ONE, 4*ONE, 0, 0, 0, 0), 0, '0});
    rows.push_back('{inv(OP_NORM, MINW, MINW, MAXW, 0, 0, 0), 0, '0});
    rows.push_back('{inv(OP_EQUAL, MAXW, MINW, 1, MAXW, MINW, 1), 1,
                     outv(0, 0, 0, 0, 1, ST_OK)});
    rows.push_back('{inv(OP_EQUAL, MAXW, MINW, 1, MAXW, MINW, 0), 1,
                     outv(0, 0, 0, 0, 0, ST_OK)});
    rows.push_back('{inv(4'd13, 1, 2, 3, 1, 2, 3), 1, outv(0, 0, 0, 0, 0, ST_OK)});
    rows.push_back('{inv(4'd15, MAXW, MAXW, MAXW, MINW, MINW, MINW), 1,
                     outv(0, 0, 0, 0, 0, ST_OK)});

    foreach (rows[i]) begin
      send_beat(rows[i].it, rows[i].has_typed, rows[i].typed);
      if (i % 5 == 4) idle_gap();
    end

    // random beats; operands mix full range, extremes and small values
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 5);
      it.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
      it.a_x = rand_word(kind);
      it.a_y = rand_word($urandom_range(0, 1) ? kind : $urandom_range(0, 5));
      it.a_z = rand_word($urandom_range(0, 5));
      it.b_x = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_word(kind);
      it.b_y = rand_word($urandom_range(0, 5));
      it.b_z = rand_word($urandom_range(0, 5));
      if (it.opcode == OP_EQUAL && $urandom_range(0, 1)) begin
        it.b_x = it.a_x; it.b_y = it.a_y;
        if ($urandom_range(0, 2) != 0) it.b_z = it.a_z;
      end
      send_beat(it, 1'b0, '0);
      if (n % 200 < 150) idle_gap();
    end
    start <= 1'b0;

    while (alu_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
